[hdl/tsd_pkg.sv]
// ----------------------------------------------------------------------------
// tsd_pkg
// Shared types and constants of the trajectory stuck detector.
// ----------------------------------------------------------------------------
package tsd_pkg;

    localparam int POS_W      = 20;
    localparam int DIFF_W     = POS_W + 1;
    localparam int SQ_W       = 2 * POS_W + 1;
    localparam int DIST_W     = 43;
    localparam int HEAD_W     = 16;
    localparam int TURN_W     = HEAD_W + 1;
    localparam int COST_W     = 24;
    localparam int SCORE_W    = 13;
    localparam int INC_W      = 12;
    localparam int DECAY_W    = 13;
    localparam int MOVE_W     = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] REG_COST_THRESHOLD    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TURN_THRESHOLD    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MOVE_THRESHOLD_SQ = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SCORE_INCREMENT   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SCORE_DECAY       = 3'd4;

    localparam logic [COST_W-1:0]   RST_COST_THRESHOLD    = 24'd2560;
    localparam logic [HEAD_W-1:0]   RST_TURN_THRESHOLD    = 16'd1024;
    localparam logic [MOVE_W-1:0]   RST_MOVE_THRESHOLD_SQ = 32'd167772;
    localparam logic [INC_W-1:0]    RST_SCORE_INCREMENT   = 12'd614;
    localparam logic [DECAY_W-1:0]  RST_SCORE_DECAY       = 13'd3277;

    localparam logic [SCORE_W-1:0] SCORE_ONE = 13'd4096;
    localparam logic [SCORE_W-1:0] SCORE_MAX = 13'd8191;

    typedef struct packed {
        logic [COST_W-1:0]  cost_threshold;
        logic [HEAD_W-1:0]  turn_threshold;
        logic [MOVE_W-1:0]  move_threshold_sq;
        logic [INC_W-1:0]   score_increment;
        logic [DECAY_W-1:0] score_decay;
    } cfg_t;

    typedef struct packed {
        logic [SQ_W-1:0]   sq_x;
        logic [SQ_W-1:0]   sq_y;
        logic [SQ_W-1:0]   sq_z;
        logic [TURN_W-1:0] turn;
        logic [COST_W-1:0] plan_cost;
        logic              airborne;
        logic              last_sample;
        logic              restart;
    } delta_t;

endpackage

[hdl/tsd_cfg_regs.sv]
// ----------------------------------------------------------------------------
// tsd_cfg_regs
// Configuration register file written through the configuration channel.
// ----------------------------------------------------------------------------
module tsd_cfg_regs (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           wr_en,
    input  logic [tsd_pkg::CFG_IDX_W-1:0]  wr_index,
    input  logic [tsd_pkg::CFG_DATA_W-1:0] wr_data,
    output tsd_pkg::cfg_t                  cfg
);
    import tsd_pkg::*;

    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.cost_threshold    <= RST_COST_THRESHOLD;
            cfg_reg.turn_threshold    <= RST_TURN_THRESHOLD;
            cfg_reg.move_threshold_sq <= RST_MOVE_THRESHOLD_SQ;
            cfg_reg.score_increment   <= RST_SCORE_INCREMENT;
            cfg_reg.score_decay       <= RST_SCORE_DECAY;
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                REG_COST_THRESHOLD:    cfg_reg.cost_threshold    <= wr_data[COST_W-1:0];
                REG_TURN_THRESHOLD:    cfg_reg.turn_threshold    <= wr_data[HEAD_W-1:0];
                REG_MOVE_THRESHOLD_SQ: cfg_reg.move_threshold_sq <= wr_data[MOVE_W-1:0];
                REG_SCORE_INCREMENT:   cfg_reg.score_increment   <= wr_data[INC_W-1:0];
                REG_SCORE_DECAY:       cfg_reg.score_decay       <= wr_data[DECAY_W-1:0];
                default:               cfg_reg <= cfg_reg;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

[hdl/tsd_delta_stage.sv]
// ----------------------------------------------------------------------------
// tsd_delta_stage
// Input register, capture of the first sample, and per-axis squared offsets
// and absolute yaw change against that first sample.
// ----------------------------------------------------------------------------
module tsd_delta_stage (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              advance,
    input  logic                              sample_valid,
    input  logic signed [tsd_pkg::POS_W-1:0]  pos_x,
    input  logic signed [tsd_pkg::POS_W-1:0]  pos_y,
    input  logic signed [tsd_pkg::POS_W-1:0]  pos_z,
    input  logic signed [tsd_pkg::HEAD_W-1:0] heading,
    input  logic [tsd_pkg::COST_W-1:0]        plan_cost,
    input  logic                              airborne,
    input  logic                              last_sample,
    output logic                              delta_valid,
    output tsd_pkg::delta_t                   delta
);
    import tsd_pkg::*;

    logic                     s1_valid_reg;
    logic signed [POS_W-1:0]  s1_x_reg;
    logic signed [POS_W-1:0]  s1_y_reg;
    logic signed [POS_W-1:0]  s1_z_reg;
    logic signed [HEAD_W-1:0] s1_h_reg;
    logic [COST_W-1:0]        s1_cost_reg;
    logic                     s1_air_reg;
    logic                     s1_last_reg;

    logic signed [POS_W-1:0]  first_x_reg;
    logic signed [POS_W-1:0]  first_y_reg;
    logic signed [POS_W-1:0]  first_z_reg;
    logic signed [HEAD_W-1:0] first_h_reg;
    logic                     at_start_reg;

    logic                     s2_valid_reg;
    delta_t                   s2_reg;
    delta_t                   s2_next;

    logic signed [POS_W-1:0]  base_x;
    logic signed [POS_W-1:0]  base_y;
    logic signed [POS_W-1:0]  base_z;
    logic signed [HEAD_W-1:0] base_h;
    logic signed [DIFF_W-1:0] dx;
    logic signed [DIFF_W-1:0] dy;
    logic signed [DIFF_W-1:0] dz;
    logic signed [TURN_W-1:0] dh;
    logic [DIFF_W-1:0]        ax;
    logic [DIFF_W-1:0]        ay;
    logic [DIFF_W-1:0]        az;
    logic [2*DIFF_W-1:0]      px;
    logic [2*DIFF_W-1:0]      py;
    logic [2*DIFF_W-1:0]      pz;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s1_valid_reg <= sample_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && sample_valid)
        begin
            s1_x_reg    <= pos_x;
            s1_y_reg    <= pos_y;
            s1_z_reg    <= pos_z;
            s1_h_reg    <= heading;
            s1_cost_reg <= plan_cost;
            s1_air_reg  <= airborne;
            s1_last_reg <= last_sample;
        end
    end

    always_comb
    begin
        base_x = at_start_reg ? s1_x_reg : first_x_reg;
        base_y = at_start_reg ? s1_y_reg : first_y_reg;
        base_z = at_start_reg ? s1_z_reg : first_z_reg;
        base_h = at_start_reg ? s1_h_reg : first_h_reg;

        dx = DIFF_W'(s1_x_reg) - DIFF_W'(base_x);
        dy = DIFF_W'(s1_y_reg) - DIFF_W'(base_y);
        dz = DIFF_W'(s1_z_reg) - DIFF_W'(base_z);
        dh = TURN_W'(s1_h_reg) - TURN_W'(base_h);

        ax = dx[DIFF_W-1] ? DIFF_W'(-dx) : DIFF_W'(dx);
        ay = dy[DIFF_W-1] ? DIFF_W'(-dy) : DIFF_W'(dy);
        az = dz[DIFF_W-1] ? DIFF_W'(-dz) : DIFF_W'(dz);

        px = ax * ax;
        py = ay * ay;
        pz = az * az;

        s2_next.sq_x        = px[SQ_W-1:0];
        s2_next.sq_y        = py[SQ_W-1:0];
        s2_next.sq_z        = pz[SQ_W-1:0];
        s2_next.turn        = dh[TURN_W-1] ? TURN_W'(-dh) : TURN_W'(dh);
        s2_next.plan_cost   = s1_cost_reg;
        s2_next.airborne    = s1_air_reg;
        s2_next.last_sample = s1_last_reg;
        s2_next.restart     = at_start_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
            at_start_reg <= 1'b1;
            first_x_reg  <= '0;
            first_y_reg  <= '0;
            first_z_reg  <= '0;
            first_h_reg  <= '0;
        end
        else if (advance)
        begin
            s2_valid_reg <= s1_valid_reg;
            if (s1_valid_reg)
            begin
                at_start_reg <= s1_last_reg;
                if (at_start_reg)
                begin
                    first_x_reg <= s1_x_reg;
                    first_y_reg <= s1_y_reg;
                    first_z_reg <= s1_z_reg;
                    first_h_reg <= s1_h_reg;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && s1_valid_reg)
        begin
            s2_reg <= s2_next;
        end
    end

    assign delta_valid = s2_valid_reg;
    assign delta       = s2_reg;

endmodule

[hdl/tsd_score_stage.sv]
// ----------------------------------------------------------------------------
// tsd_score_stage
// Running maxima of turn and squared displacement, the stuck score update on
// the last sample, and the result register.
// ----------------------------------------------------------------------------
module tsd_score_stage (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            advance,
    input  logic                            delta_valid,
    input  tsd_pkg::delta_t                 delta,
    input  tsd_pkg::cfg_t                   cfg,
    output logic                            result_valid,
    output logic                            stuck,
    output logic [tsd_pkg::SCORE_W-1:0]     score_after
);
    import tsd_pkg::*;

    logic [TURN_W-1:0]        max_turn_reg;
    logic [DIST_W-1:0]        max_dist_reg;
    logic [SCORE_W-1:0]       score_reg;
    logic                     result_valid_reg;
    logic                     stuck_reg;
    logic [SCORE_W-1:0]       score_after_reg;

    logic [DIST_W-1:0]        dist_sum;
    logic [TURN_W-1:0]        cur_turn;
    logic [DIST_W-1:0]        cur_dist;
    logic [TURN_W-1:0]        max_turn_next;
    logic [DIST_W-1:0]        max_dist_next;
    logic                     far;
    logic                     no_turn;
    logic                     no_move;
    logic [SCORE_W:0]         inc_sum;
    logic [SCORE_W+DECAY_W-1:0] decay_prod;
    logic [SCORE_W:0]         raised;
    logic [SCORE_W-1:0]       saturated;
    logic                     hit;
    logic [SCORE_W-1:0]       score_next;

    always_comb
    begin
        dist_sum = DIST_W'(delta.sq_x) + DIST_W'(delta.sq_y) + DIST_W'(delta.sq_z);
        cur_turn = delta.restart ? '0 : max_turn_reg;
        cur_dist = delta.restart ? '0 : max_dist_reg;
        max_turn_next = (delta.turn > cur_turn) ? delta.turn : cur_turn;
        max_dist_next = (dist_sum > cur_dist) ? dist_sum : cur_dist;

        far     = delta.plan_cost > cfg.cost_threshold;
        no_turn = max_turn_next < TURN_W'(cfg.turn_threshold);
        no_move = max_dist_next < DIST_W'(cfg.move_threshold_sq);

        inc_sum    = (SCORE_W+1)'(score_reg) + (SCORE_W+1)'(cfg.score_increment);
        decay_prod = (SCORE_W+DECAY_W)'(score_reg) * (SCORE_W+DECAY_W)'(cfg.score_decay);
        raised     = (far && no_turn && no_move) ? inc_sum
                                                 : decay_prod[SCORE_W+12:12];
        saturated  = (raised > (SCORE_W+1)'(SCORE_MAX)) ? SCORE_MAX : raised[SCORE_W-1:0];
        hit        = saturated > SCORE_ONE;

        if (delta.airborne)
        begin
            score_next = hit ? '0 : saturated;
        end
        else
        begin
            score_next = score_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_turn_reg     <= '0;
            max_dist_reg     <= '0;
            score_reg        <= '0;
            result_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            result_valid_reg <= delta_valid && delta.last_sample;
            if (delta_valid)
            begin
                max_turn_reg <= max_turn_next;
                max_dist_reg <= max_dist_next;
                if (delta.last_sample)
                begin
                    score_reg <= score_next;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && delta_valid && delta.last_sample)
        begin
            stuck_reg       <= delta.airborne && hit;
            score_after_reg <= score_next;
        end
    end

    assign result_valid = result_valid_reg;
    assign stuck        = stuck_reg;
    assign score_after  = score_after_reg;

endmodule

[hdl/trajectory_stuck_detector.sv]
// ----------------------------------------------------------------------------
// trajectory_stuck_detector
// Detects a vehicle that keeps planning without turning or moving.
// ----------------------------------------------------------------------------
// Samples of a planned trajectory enter on the sample channel, one per
// transaction, with last_sample marking the final one. Each trajectory that
// ends produces exactly one transaction on the result channel, carrying the
// stuck flag and the updated stuck score; other samples produce none.
// The block is a three-register pipeline: input register, squared offset
// register, result register. A result passes through the squared offset and
// result registers after its last sample is accepted, and one sample is
// accepted every cycle while sample_stall is low. When result_stall holds a
// waiting result, the whole pipeline freezes and sample_stall rises in the
// same cycle; no transaction is lost. Reset clears the pipeline, the stuck
// score and the running maxima, and loads the default thresholds.
// Configuration writes are always accepted (cfg_ready is tied high) and
// should be issued only while the pipeline is empty.
// ----------------------------------------------------------------------------
module trajectory_stuck_detector (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              sample_valid,
    output logic                              sample_stall,
    input  logic signed [tsd_pkg::POS_W-1:0]  pos_x,
    input  logic signed [tsd_pkg::POS_W-1:0]  pos_y,
    input  logic signed [tsd_pkg::POS_W-1:0]  pos_z,
    input  logic signed [tsd_pkg::HEAD_W-1:0] heading,
    input  logic [tsd_pkg::COST_W-1:0]        plan_cost,
    input  logic                              airborne,
    input  logic                              last_sample,
    output logic                              result_valid,
    input  logic                              result_stall,
    output logic                              stuck,
    output logic [tsd_pkg::SCORE_W-1:0]       score_after,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [tsd_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [tsd_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import tsd_pkg::*;

    cfg_t   cfg;
    delta_t delta;
    logic   delta_valid;
    logic   advance;

    assign cfg_ready    = 1'b1;
    assign advance      = !(result_valid && result_stall);
    assign sample_stall = !advance;

    tsd_cfg_regs u_cfg_regs (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid && cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    tsd_delta_stage u_delta_stage (
        .clk          (clk),
        .rst_n        (rst_n),
        .advance      (advance),
        .sample_valid (sample_valid),
        .pos_x        (pos_x),
        .pos_y        (pos_y),
        .pos_z        (pos_z),
        .heading      (heading),
        .plan_cost    (plan_cost),
        .airborne     (airborne),
        .last_sample  (last_sample),
        .delta_valid  (delta_valid),
        .delta        (delta)
    );

    tsd_score_stage u_score_stage (
        .clk          (clk),
        .rst_n        (rst_n),
        .advance      (advance),
        .delta_valid  (delta_valid),
        .delta        (delta),
        .cfg          (cfg),
        .result_valid (result_valid),
        .stuck        (stuck),
        .score_after  (score_after)
    );

endmodule

[hdl/tsd_checker.sv]
// ----------------------------------------------------------------------------
// tsd_checker
// Port-level checks of the trajectory stuck detector, bound to the top level.
// ----------------------------------------------------------------------------
module tsd_checker (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        sample_stall,
    input  logic                        result_valid,
    input  logic                        result_stall,
    input  logic                        stuck,
    input  logic [tsd_pkg::SCORE_W-1:0] score_after
);
    import tsd_pkg::*;

    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid)
        else $error("A stalled result transaction was withdrawn.");

    a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        sample_stall == (result_valid && result_stall))
        else $error("Sample stall does not follow result backpressure.");

    a_stuck_clears: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && stuck |-> score_after == '0)
        else $error("A stuck result carries a nonzero score.");

    a_score_bound: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> score_after <= SCORE_ONE)
        else $error("Reported score exceeds one.");

    a_no_result_from_reset: assert property (@(posedge clk)
        $rose(rst_n) |-> !result_valid)
        else $error("A result transaction appeared straight out of reset.");

endmodule

bind trajectory_stuck_detector tsd_checker u_tsd_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .sample_stall (sample_stall),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .stuck        (stuck),
    .score_after  (score_after)
);
